// File: sv/hgp_pkg.sv
`timescale 1ns / 1ps
package hgp_pkg;

   localparam int PATH_LIMIT_DEF = 159;

   // Results one request byte can produce, and the result queue behind the step logic.
   // The queue depth must stay a power of two so its pointers wrap on their own.
   localparam int RSP_PER_BYTE = 4;
   localparam int SLOT_W       = $clog2(RSP_PER_BYTE);
   localparam int PUSH_W       = $clog2(RSP_PER_BYTE + 1);
   localparam int RQ_DEPTH     = 8;
   localparam int RQ_IDX_W     = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_W     = $clog2(RQ_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_METHOD,
      PH_SKIP,
      PH_PATH,
      PH_DRAIN
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_METHOD = 2'd1,
      ST_FORBIDDEN  = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] req_byte;
      logic       end_of_request;
   } req_type;

   typedef struct packed {
      logic [7:0] path_byte;
      logic       byte_valid;
      logic       done_res;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      phase_type  phase;
      logic [1:0] position;
      logic [1:0] pend_count;
      logic [7:0] pend_hex;
      logic       prev_dot;
      logic       emitted_any;
      logic       forbidden;
      logic       path_cut;
   } parse_state_type;

   typedef struct packed {
      logic [PUSH_W-1:0]                count;
      rsp_type [RSP_PER_BYTE-1:0]       items;
   } push_type;

   localparam parse_state_type ST_CLEAR = '{
      phase:       PH_METHOD,
      position:    2'd0,
      pend_count:  2'd0,
      pend_hex:    8'h00,
      prev_dot:    1'b0,
      emitted_any: 1'b0,
      forbidden:   1'b0,
      path_cut:    1'b0
   };

endpackage

// File: sv/http_get_path_parser.sv
`timescale 1ns / 1ps
// GET request path extractor with percent decoding. Request bytes enter one beat at a time on
// req_*; end_of_request marks the last byte of a request, and the next byte begins a new one.
// Each byte lands in an input register, is processed against the parser
// state, and yields zero to four result beats (decoded path bytes, then one final beat with
// done_res set and the status: 0 ok, 1 method not allowed, 2 forbidden path). Results wait in
// an 8-entry queue and leave one per cycle on rsp_* while rsp_ready is high. A byte is
// accepted every cycle as long as the queue keeps four free entries, so the input runs at
// one byte per cycle whenever bytes average at most one result each and rsp_ready stays
// high; the single output port sets the rate otherwise. A result is offered on rsp_* only
// after its byte has passed the input register and it has been written into the queue.
// Paths are cut after PATH_LIMIT raw path bytes.
module http_get_path_parser import hgp_pkg::*; #(
   parameter int PATH_LIMIT = PATH_LIMIT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(PATH_LIMIT + 1);

   logic            in_vld_ff, in_vld_in;
   req_type         in_item_ff, in_item_in;
   parse_state_type st_ff, st_in;
   logic [CNT_W-1:0] rc_ff, rc_in;
   push_type        step_push;
   push_type        q_push;
   logic            room;
   logic            take;
   logic            req_beat;

   // Process the held byte only when the queue can absorb its whole burst.
   assign take      = in_vld_ff && room;
   assign req_ready = !in_vld_ff || take;
   assign req_beat  = req_valid && req_ready;

   assign in_vld_in  = req_beat ? 1'b1 : (take ? 1'b0 : in_vld_ff);
   assign in_item_in = req_beat ? req_data : in_item_ff;

   hgp_step #(
      .PATH_LIMIT(PATH_LIMIT)
   ) u_step (
      .st_cur (st_ff),
      .rc_cur (rc_ff),
      .item   (in_item_ff),
      .st_nxt (st_in),
      .rc_nxt (rc_in),
      .push   (step_push)
   );

   // Push nothing on cycles where the held byte is not consumed.
   always_comb begin
      q_push       = step_push;
      q_push.count = take ? step_push.count : '0;
   end

   hgp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   // Advance parser state only on consumed bytes.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         st_ff     <= ST_CLEAR;
         rc_ff     <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         if (take) begin
            st_ff <= st_in;
            rc_ff <= rc_in;
         end
      end
   end

endmodule

// File: sv/hgp_step.sv
`timescale 1ns / 1ps
module hgp_step import hgp_pkg::*; #(
   parameter int PATH_LIMIT = PATH_LIMIT_DEF,
   localparam int CNT_W = $clog2(PATH_LIMIT + 1)
) (
   input  parse_state_type st_cur,
   input  logic [CNT_W-1:0] rc_cur,
   input  req_type          item,
   output parse_state_type st_nxt,
   output logic [CNT_W-1:0] rc_nxt,
   output push_type         push
);

   localparam logic [7:0] CH_G     = 8'h47;
   localparam logic [7:0] CH_E     = 8'h45;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_QUES  = 8'h3F;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;

   typedef struct packed {
      parse_state_type            st;
      rsp_type [RSP_PER_BYTE-1:0] res;
      logic [PUSH_W-1:0]          n;
   } work_type;

   function automatic logic hex_ok(logic [7:0] c);
      return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF) ||
             (c >= CH_LA && c <= CH_LF);
   endfunction

   // Letters of either case carry their value in the low nibble plus nine.
   function automatic logic [3:0] hex_val(logic [7:0] c);
      logic [3:0] v;
      if (c <= CH_9) begin
         v = c[3:0];
      end else begin
         v = c[3:0] + 4'd9;
      end
      return v;
   endfunction

   // Drop results beyond the per-byte limit.
   function automatic work_type put_res(work_type w, logic [7:0] b, logic bv, logic dn,
                                        logic [1:0] s);
      work_type r;
      r = w;
      if (r.n < PUSH_W'(RSP_PER_BYTE)) begin
         r.res[r.n[SLOT_W-1:0]] = '{path_byte: b, byte_valid: bv, done_res: dn, status: s};
         r.n = r.n + PUSH_W'(1);
      end
      return r;
   endfunction

   function automatic work_type emit_byte(work_type w, logic [7:0] b);
      work_type r;
      r = w;
      if (!r.st.path_cut) begin
         if (b == CH_NUL) begin
            r.st.path_cut = 1'b1;
         end else begin
            if (!r.st.emitted_any && b != CH_SLASH) begin
               r.st.forbidden = 1'b1;
            end
            if (r.st.prev_dot && b == CH_DOT) begin
               r.st.forbidden = 1'b1;
            end
            r.st.prev_dot    = (b == CH_DOT);
            r.st.emitted_any = 1'b1;
            r = put_res(r, b, 1'b1, 1'b0, ST_OK);
         end
      end
      return r;
   endfunction

   function automatic work_type feed_plain(work_type w, logic [7:0] c);
      work_type r;
      r = w;
      if (c == CH_PCT) begin
         r.st.pend_count = 2'd1;
      end else begin
         r = emit_byte(r, c);
      end
      return r;
   endfunction

   function automatic work_type feed(work_type w, logic [7:0] c);
      work_type r;
      r = w;
      case (r.st.pend_count)
         2'd0: begin
            r = feed_plain(r, c);
         end
         2'd1: begin
            if (hex_ok(c)) begin
               r.st.pend_hex   = c;
               r.st.pend_count = 2'd2;
            end else begin
               r.st.pend_count = 2'd0;
               r = emit_byte(r, CH_PCT);
               r = feed_plain(r, c);
            end
         end
         default: begin
            r.st.pend_count = 2'd0;
            if (hex_ok(c) && hex_ok(r.st.pend_hex)) begin
               r = emit_byte(r, {hex_val(r.st.pend_hex), hex_val(c)});
            end else begin
               r = emit_byte(r, CH_PCT);
               r = emit_byte(r, r.st.pend_hex);
               r = feed_plain(r, c);
            end
         end
      endcase
      return r;
   endfunction

   function automatic work_type finish_path(work_type w);
      work_type r;
      r = w;
      if (r.st.pend_count >= 2'd1) begin
         r = emit_byte(r, CH_PCT);
      end
      if (r.st.pend_count >= 2'd2) begin
         r = emit_byte(r, r.st.pend_hex);
      end
      r.st.pend_count = 2'd0;
      if (!r.st.emitted_any) begin
         r = put_res(r, CH_SLASH, 1'b1, 1'b0, ST_OK);
      end
      r = put_res(r, CH_NUL, 1'b0, 1'b1, r.st.forbidden ? ST_FORBIDDEN : ST_OK);
      r.st.phase = PH_DRAIN;
      return r;
   endfunction

   work_type   w;
   logic [7:0] want;
   logic [7:0] c;

   always_comb begin
      w.st  = st_cur;
      w.res = '0;
      w.n   = '0;
      c     = item.req_byte;
      want  = CH_T;
      rc_nxt = rc_cur;
      case (st_cur.phase)
         PH_METHOD: begin
            if (st_cur.position == 2'd0) begin
               want = CH_G;
            end else if (st_cur.position == 2'd1) begin
               want = CH_E;
            end
            if (c != want) begin
               w = put_res(w, CH_NUL, 1'b0, 1'b1, ST_BAD_METHOD);
               w.st.phase = PH_DRAIN;
            end else begin
               w.st.position = w.st.position + 2'd1;
               if (w.st.position == 2'd3) begin
                  w.st.phase = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            w.st.phase = PH_PATH;
         end
         PH_PATH: begin
            if (c == CH_SPACE || c == CH_CR || c == CH_NUL || c == CH_QUES) begin
               w = finish_path(w);
            end else begin
               w = feed(w, c);
               rc_nxt = rc_cur + CNT_W'(1);
               if (rc_nxt >= CNT_W'(PATH_LIMIT)) begin
                  w = finish_path(w);
               end
            end
         end
         default: begin
            w.st.phase = PH_DRAIN;
         end
      endcase

      if (item.end_of_request) begin
         if (w.st.phase == PH_METHOD) begin
            w = put_res(w, CH_NUL, 1'b0, 1'b1, ST_BAD_METHOD);
         end else if (w.st.phase == PH_SKIP || w.st.phase == PH_PATH) begin
            w = finish_path(w);
         end
         w.st   = ST_CLEAR;
         rc_nxt = '0;
      end
   end

   assign st_nxt     = w.st;
   assign push.count = w.n;
   assign push.items = w.res;

endmodule

// File: sv/hgp_rsp_queue.sv
`timescale 1ns / 1ps
module hgp_rsp_queue import hgp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   rsp_type               mem_ff [RQ_DEPTH];
   logic [RQ_IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RQ_IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RQ_CNT_W-1:0]   count_ff, count_in;
   logic                  pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   // Room for a full burst from one byte, ignoring this cycle's pop.
   assign room      = (count_ff <= RQ_CNT_W'(RQ_DEPTH - RSP_PER_BYTE));

   assign wr_ptr_in = wr_ptr_ff + RQ_IDX_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + RQ_IDX_W'(pop);
   assign count_in  = count_ff + RQ_CNT_W'(push.count) - RQ_CNT_W'(pop);

   always_ff @(posedge clock) begin
      for (int k = 0; k < RSP_PER_BYTE; k++) begin
         if (PUSH_W'(k) < push.count) begin
            mem_ff[wr_ptr_ff + RQ_IDX_W'(k)] <= push.items[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/hgp_checker.sv
`timescale 1ns / 1ps
module hgp_checker import hgp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("queue not empty or input blocked after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.byte_valid ^ rsp_data.done_res))
      else $error("result beat is neither a path byte nor a final status");

   a_path_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.byte_valid |-> rsp_data.path_byte != 8'h00 &&
                                           rsp_data.status == ST_OK)
      else $error("zero path byte or status on a path byte beat");

endmodule

bind http_get_path_parser hgp_checker u_hgp_checker (.*);
